[rtl/core/mwv_pkg.sv]
// Shared constants and types of the moving window variance block.
package mwv_pkg;

    localparam int MAX_WINDOW  = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
    localparam int LEN_BITS    = 11;
    localparam int SUM_BITS    = 27;
    localparam int SQS_BITS    = 41;
    localparam int DVD_BITS    = 64;
    localparam int DVS_BITS    = 22;
    localparam int CNT_BITS    = $clog2(DVD_BITS);

    typedef struct packed {
        logic                start;
        logic [DVD_BITS-1:0] dividend;
        logic [DVS_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DVD_BITS-1:0] quot;
        logic [DVS_BITS-1:0] rem;
    } t_div_rsp;

endpackage

[rtl/core/mwv_hist_ram.sv]
// Sample history memory with one write port and one registered read port.
module mwv_hist_ram (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [mwv_pkg::ADDR_BITS-1:0]       i_waddr,
    input  logic [mwv_pkg::SAMPLE_BITS-1:0]     i_wdata,
    input  logic                                i_re,
    input  logic [mwv_pkg::ADDR_BITS-1:0]       i_raddr,
    output logic [mwv_pkg::SAMPLE_BITS-1:0]     o_rdata
);

    logic [mwv_pkg::SAMPLE_BITS-1:0] r_mem [mwv_pkg::MAX_WINDOW];
    logic [mwv_pkg::SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mwv_div.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
module mwv_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mwv_pkg::t_div_req i_req,
    output mwv_pkg::t_div_rsp o_rsp
);

    logic [mwv_pkg::DVD_BITS-1:0] r_dvd;
    logic [mwv_pkg::DVS_BITS-1:0] r_dvs;
    logic [mwv_pkg::DVS_BITS-1:0] r_rem;
    logic [mwv_pkg::CNT_BITS-1:0] r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [mwv_pkg::DVS_BITS:0]   n_shift;
    logic                         n_ge;

    always_comb begin
        n_shift = {r_rem, r_dvd[mwv_pkg::DVD_BITS-1]};
        n_ge    = n_shift >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[mwv_pkg::DVD_BITS-2:0], n_ge};
                if (n_ge) begin
                    r_rem <= mwv_pkg::DVS_BITS'(n_shift - {1'b0, r_dvs});
                end else begin
                    r_rem <= n_shift[mwv_pkg::DVS_BITS-1:0];
                end
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;
    assign o_rsp.rem  = r_rem;

endmodule

[rtl/core/moving_window_variance.sv]
// Top level of the sliding window sum, mean and variance block.
//
// One signed 16-bit sample word enters on the slave stream channel. The block
// keeps the last n samples in a history memory, with a running sum and a
// running sum of squares, where n is the window length register (zero acts as
// one, values above 1024 act as 1024). Once the window holds n samples, every
// sample word yields one result word on the master stream channel: the window
// sum, the mean floor(S*256/n) and the population variance
// floor((n*Q-S*S)*256/(n*n)), both with 8 fraction bits.
// A sample that completes the window yields its result word after the memory
// read of the leaving sample, squaring, sum update, the products, two passes
// of the shared bit-serial divider (mean, then variance) and the output load;
// the next sample can be taken in the cycle after the output load. Samples that
// do not complete the window return to idle after the sum update.
// A new sample is taken while a finished result still waits in the output
// register; when the receiver stalls, the next result waits in the sequencer
// until the output register is free. Reset sets the window length to 16 and
// empties the window; a write of the window length also empties it. The
// history memory needs no clearing since only written entries are used.
module moving_window_variance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,   // window_length
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,     // sample
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata      // window_sum, window_mean, window_variance
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_READ = 4'd1;
    localparam logic [3:0] ST_UPD  = 4'd2;
    localparam logic [3:0] ST_MUL1 = 4'd3;
    localparam logic [3:0] ST_MUL2 = 4'd4;
    localparam logic [3:0] ST_DIVM = 4'd5;
    localparam logic [3:0] ST_DIVV = 4'd6;
    localparam logic [3:0] ST_DONE = 4'd7;
    localparam logic [3:0] ST_SQR  = 4'd8;

    localparam int AW = mwv_pkg::ADDR_BITS;
    localparam int LW = mwv_pkg::LEN_BITS;
    localparam int SB = mwv_pkg::SAMPLE_BITS;

    logic [3:0]                  r_state;
    logic [LW-1:0]               r_len;
    logic [LW-1:0]               r_fill;
    logic [AW-1:0]               r_wp;
    logic signed [mwv_pkg::SUM_BITS-1:0] r_sum;
    logic [mwv_pkg::SQS_BITS-1:0] r_sqs;
    logic [LW-1:0]               r_n;
    logic                        r_full;
    logic signed [SB-1:0]        r_smp;
    logic signed [SB-1:0]        r_old;
    logic [2*SB-1:0]             r_sq_new;
    logic [2*SB-1:0]             r_sq_old;
    logic [31:0]                 r_p0;
    logic [51:0]                 r_ss;
    logic [20:0]                 r_nn;
    logic [25:0]                 r_mag;
    logic                        r_neg;
    logic [63:0]                 r_spread;
    logic [23:0]                 r_mean;
    logic [38:0]                 r_var;
    logic                        r_out_valid;
    logic [95:0]                 r_out;

    logic [LW-1:0]               n_len;
    logic                        n_accept;
    logic [AW-1:0]               n_old_idx;
    logic [SB-1:0]               n_rdata;
    logic [25:0]                 n_mag;
    logic [30:0]                 n_p1;
    logic [24:0]                 n_mean;
    mwv_pkg::t_div_req           n_req;
    mwv_pkg::t_div_rsp           n_rsp;

    always_comb begin
        if (r_len == '0) begin
            n_len = LW'(1);
        end else if (r_len > LW'(mwv_pkg::MAX_WINDOW)) begin
            n_len = LW'(mwv_pkg::MAX_WINDOW);
        end else begin
            n_len = r_len;
        end
        n_accept  = i_s_tvalid && o_s_tready;
        n_old_idx = r_wp - n_len[AW-1:0];
        n_mag     = r_sum[mwv_pkg::SUM_BITS-1] ? 26'(-r_sum) : r_sum[25:0];
        n_p1      = 31'(r_n * r_sqs[40:21]);
        n_mean    = r_neg ? 25'(-({1'b0, n_rsp.quot[23:0]} + 25'(n_rsp.rem != '0)))
                          : {1'b0, n_rsp.quot[23:0]};
        n_req          = '0;
        if (r_state == ST_MUL2) begin
            n_req.start    = 1'b1;
            n_req.dividend = {30'd0, r_mag, 8'd0};
            n_req.divisor  = {11'd0, r_n};
        end else if (r_state == ST_DIVM && n_rsp.done) begin
            n_req.start    = 1'b1;
            n_req.dividend = {r_spread[55:0], 8'd0};
            n_req.divisor  = {1'b0, r_nn};
        end
    end

    mwv_hist_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (n_accept),
        .i_waddr (r_wp),
        .i_wdata (i_s_tdata),
        .i_re    (n_accept),
        .i_raddr (n_old_idx),
        .o_rdata (n_rdata)
    );

    mwv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_rsp   (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= LW'(16);
            r_fill      <= '0;
            r_wp        <= '0;
            r_sum       <= '0;
            r_sqs       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_len  <= i_cfg_wdata;
                r_fill <= '0;
                r_sum  <= '0;
                r_sqs  <= '0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_smp  <= i_s_tdata;
                        r_n    <= n_len;
                        r_full <= r_fill >= n_len;
                        r_wp   <= r_wp + 1'b1;
                        r_fill <= (r_fill >= n_len) ? n_len : r_fill + 1'b1;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_old   <= r_full ? n_rdata : '0;
                    r_state <= ST_SQR;
                end
                ST_SQR: begin
                    r_sq_new <= 32'(r_smp * r_smp);
                    r_sq_old <= 32'(r_old * r_old);
                    r_state  <= ST_UPD;
                end
                ST_UPD: begin
                    r_sum <= r_sum - mwv_pkg::SUM_BITS'(r_old) + mwv_pkg::SUM_BITS'(r_smp);
                    r_sqs <= r_sqs - mwv_pkg::SQS_BITS'(r_sq_old)
                                   + mwv_pkg::SQS_BITS'(r_sq_new);
                    r_state <= (r_fill >= r_n) ? ST_MUL1 : ST_IDLE;
                end
                ST_MUL1: begin
                    r_mag   <= n_mag;
                    r_neg   <= r_sum[mwv_pkg::SUM_BITS-1];
                    r_ss    <= 52'(n_mag * n_mag);
                    r_p0    <= 32'(r_n * r_sqs[20:0]);
                    r_nn    <= 21'(r_n * r_n);
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_spread <= 64'(r_p0) + (64'(n_p1) << 21) - 64'(r_ss);
                    r_state  <= ST_DIVM;
                end
                ST_DIVM: begin
                    if (n_rsp.done) begin
                        r_mean  <= n_mean[23:0];
                        r_state <= ST_DIVV;
                    end
                end
                ST_DIVV: begin
                    if (n_rsp.done) begin
                        r_var   <= n_rsp.quot[38:0];
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out       <= {7'd0, r_var, r_mean, r_sum[25:0]};
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE) && !i_cfg_we;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

[rtl/core/mwv_checker.sv]
// Port-level assertions for the moving window variance block.
module mwv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [95:0] o_m_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Result word present right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled result word changed.");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[95:89] == 7'd0)
        else $error("Padding bits of the result word are not zero.");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("Sample word taken while the previous one is in work.");

endmodule

bind moving_window_variance mwv_checker u_mwv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
